### rtl/core/gap_timed_frame_receiver_crc_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame receiver checker
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GAP_TIMED_FRAME_RECEIVER_CRC_UNIT_ASSERT_SVH
`define GAP_TIMED_FRAME_RECEIVER_CRC_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GTFR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GTFR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gtfr_pkg.sv
// ----------------------------------------------------------------------------
// gtfr_pkg
// Types, constants and the CRC16 byte update of the frame receiver.
// ----------------------------------------------------------------------------
package gtfr_pkg;

  localparam int MAX_FRAME = 1024;
  localparam int ADDR_W    = $clog2(MAX_FRAME);
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int CMP_W     = 16;
  localparam int CFG_W     = 11;
  localparam int BYTE_W    = 8;
  localparam int IDX_W     = 10;
  localparam int PDU_W     = 10;
  localparam int EV_W      = 3;

  // frame layout
  localparam int POS_CRC_START = 2;
  localparam int POS_CRC_LO    = 10;
  localparam int POS_CRC_HI    = 11;
  localparam int POS_SRC       = 20;
  localparam int POS_DST       = 21;
  localparam int HDR_BYTES     = 18;
  localparam int RUNT_BYTES    = 5;

  localparam logic [CFG_W-1:0] MIN_FRAME_RESET = CFG_W'(22);
  localparam logic [15:0]      CRC_INIT        = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY        = 16'hA001;

  typedef enum logic [1:0] {
    MODE_INIT,
    MODE_IDLE,
    MODE_RCV,
    MODE_ERROR
  } mode_t;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_TIMEOUT,
    OP_START,
    OP_READ
  } op_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE,
    EV_RDY,
    EV_FRAME_OK,
    EV_CRC_ERR,
    EV_TOO_SHORT,
    EV_RUNT,
    EV_OVERFLOW
  } event_t;

  // result of one item before the store read data is merged in
  typedef struct packed {
    event_t             ev;
    logic               restart;
    logic               stop;
    logic [BYTE_W-1:0]  src;
    logic [BYTE_W-1:0]  dst;
    logic [PDU_W-1:0]   plen;
    logic               rd_pass;
    logic               rvalid;
  } res_t;

  // reflected CRC16, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                           input logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/gtfr_ram.sv
// ----------------------------------------------------------------------------
// gtfr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gtfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/gap_timed_frame_receiver_crc_unit.sv
// ----------------------------------------------------------------------------
// gap_timed_frame_receiver_crc_unit
// Serial frame receiver: frame store, on-the-fly Modbus CRC16, gap-timeout
// frame evaluation and buffer read-back.
// ----------------------------------------------------------------------------
//
//  channel  | dir | ports                                   | transfer when
//  ---------+-----+-----------------------------------------+-------------------
//  input    | in  | in_valid/in_stall, in_operation,        | valid & !stall
//           |     | in_rx_byte, in_read_index               |
//  result   | out | out_valid/out_stall, out_event_res ...  | valid & !stall
//           |     | out_read_valid                          |
//  config   | in  | cfg_wr_en, cfg_wr_data (min_frame_bytes)| wr_en
//
//  One item per cycle while out_stall does not hold the pipeline. A result
//  passes the state update and frame store access into the s1 register, then
//  the registered read port of the store into the output register.
//  Reset is synchronous (rst_n low). Control state resets at once; the frame
//  store has no clearing pass and is undefined until written.
//  out_stall backs up through the single stage in front of the output
//  register and raises in_stall in the same cycle.
//
module gap_timed_frame_receiver_crc_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // config
  input  logic                        cfg_wr_en,
  input  logic [gtfr_pkg::CFG_W-1:0]  cfg_wr_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [gtfr_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic [gtfr_pkg::IDX_W-1:0]  in_read_index,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gtfr_pkg::EV_W-1:0]   out_event_res,
  output logic                        out_timer_restart,
  output logic                        out_timer_stop,
  output logic [gtfr_pkg::BYTE_W-1:0] out_source_addr,
  output logic [gtfr_pkg::BYTE_W-1:0] out_dest_addr,
  output logic [gtfr_pkg::PDU_W-1:0]  out_pdu_length,
  output logic [gtfr_pkg::BYTE_W-1:0] out_read_byte,
  output logic                        out_read_valid
);

  localparam int CMP_W = gtfr_pkg::CMP_W;

  // receiver state
  gtfr_pkg::mode_t                mode_r, mode_nxt;
  logic [gtfr_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [15:0]                    crc_r, crc_nxt;
  logic [15:0]                    exp_r, exp_nxt;
  logic [gtfr_pkg::BYTE_W-1:0]    src_r, src_nxt;
  logic [gtfr_pkg::BYTE_W-1:0]    dst_r, dst_nxt;
  // offsets 10/11 zeroed by a checked frame; reads see 0 until rewritten
  logic                           z10_r, z10_nxt;
  logic                           z11_r, z11_nxt;
  logic [gtfr_pkg::CFG_W-1:0]     min_r;

  // pipeline
  logic                           s1_valid_r;
  gtfr_pkg::res_t                 s1_r, s1_nxt;
  logic                           out_valid_r;
  logic                           s1_move;
  logic                           in_acc;

  // frame store port
  logic                           mem_we, mem_re;
  logic [gtfr_pkg::ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [gtfr_pkg::BYTE_W-1:0]    mem_rdata;

  // byte placement
  logic [gtfr_pkg::CNT_W-1:0]     pos;
  logic [CMP_W-1:0]               pos_x, cnt_x, min_x, ridx_x, plen_x;
  logic [15:0]                    crc_base;
  logic [gtfr_pkg::BYTE_W-1:0]    fed;
  logic                           take;

  assign s1_move  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_move;
  assign in_acc   = in_valid && !in_stall;

  // a byte opens a frame in idle mode at offset 0, else lands at the count
  assign pos    = (mode_r == gtfr_pkg::MODE_IDLE) ? '0 : count_r;
  assign pos_x  = CMP_W'(pos);
  assign cnt_x  = CMP_W'(count_r);
  assign min_x  = CMP_W'(min_r);
  assign ridx_x = CMP_W'(in_read_index);
  assign plen_x = cnt_x - CMP_W'(gtfr_pkg::HDR_BYTES);

  assign crc_base = (mode_r == gtfr_pkg::MODE_IDLE) ? gtfr_pkg::CRC_INIT : crc_r;
  // CRC field itself is fed as zero
  assign fed = (pos_x == CMP_W'(gtfr_pkg::POS_CRC_LO) ||
                pos_x == CMP_W'(gtfr_pkg::POS_CRC_HI)) ? '0 : in_rx_byte;

  assign take = (mode_r == gtfr_pkg::MODE_IDLE) ||
                (mode_r == gtfr_pkg::MODE_RCV && cnt_x < CMP_W'(gtfr_pkg::MAX_FRAME));

  assign mem_waddr = pos[gtfr_pkg::ADDR_W-1:0];
  assign mem_raddr = ridx_x[gtfr_pkg::ADDR_W-1:0];

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    crc_nxt   = crc_r;
    exp_nxt   = exp_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    z10_nxt   = z10_r;
    z11_nxt   = z11_r;
    s1_nxt    = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    if (in_acc) begin
      unique case (gtfr_pkg::op_t'(in_operation))
        gtfr_pkg::OP_BYTE: begin
          s1_nxt.restart = 1'b1;
          if (take) begin
            mem_we    = 1'b1;
            count_nxt = pos + gtfr_pkg::CNT_W'(1);
            mode_nxt  = gtfr_pkg::MODE_RCV;
            crc_nxt   = (pos_x >= CMP_W'(gtfr_pkg::POS_CRC_START)) ?
                        gtfr_pkg::crc_feed(crc_base, fed) : crc_base;
            if (mode_r == gtfr_pkg::MODE_IDLE) begin
              exp_nxt = '0;
              src_nxt = '0;
              dst_nxt = '0;
            end
            priority if (pos_x == CMP_W'(gtfr_pkg::POS_CRC_LO)) begin
              exp_nxt[7:0] = in_rx_byte;
              z10_nxt      = 1'b0;
            end else if (pos_x == CMP_W'(gtfr_pkg::POS_CRC_HI)) begin
              exp_nxt[15:8] = in_rx_byte;
              z11_nxt       = 1'b0;
            end else if (pos_x == CMP_W'(gtfr_pkg::POS_SRC)) begin
              src_nxt = in_rx_byte;
            end else if (pos_x == CMP_W'(gtfr_pkg::POS_DST)) begin
              dst_nxt = in_rx_byte;
            end
          end else if (mode_r == gtfr_pkg::MODE_RCV) begin
            // store full
            mode_nxt  = gtfr_pkg::MODE_ERROR;
            s1_nxt.ev = gtfr_pkg::EV_OVERFLOW;
          end
        end
        gtfr_pkg::OP_TIMEOUT: begin
          s1_nxt.stop = 1'b1;
          mode_nxt    = gtfr_pkg::MODE_IDLE;
          unique case (mode_r)
            gtfr_pkg::MODE_INIT: begin
              s1_nxt.ev = gtfr_pkg::EV_RDY;
            end
            gtfr_pkg::MODE_RCV: begin
              priority if (cnt_x < CMP_W'(gtfr_pkg::RUNT_BYTES)) begin
                s1_nxt.ev = gtfr_pkg::EV_RUNT;
              end else if (cnt_x < min_x) begin
                s1_nxt.ev = gtfr_pkg::EV_TOO_SHORT;
              end else begin
                if (cnt_x > CMP_W'(gtfr_pkg::POS_CRC_LO)) begin
                  z10_nxt = 1'b1;
                end
                if (cnt_x > CMP_W'(gtfr_pkg::POS_CRC_HI)) begin
                  z11_nxt = 1'b1;
                end
                if (crc_r == exp_r) begin
                  s1_nxt.ev   = gtfr_pkg::EV_FRAME_OK;
                  s1_nxt.src  = src_r;
                  s1_nxt.dst  = dst_r;
                  s1_nxt.plen = (cnt_x > CMP_W'(gtfr_pkg::HDR_BYTES)) ?
                                plen_x[gtfr_pkg::PDU_W-1:0] : '0;
                end else begin
                  s1_nxt.ev = gtfr_pkg::EV_CRC_ERR;
                end
              end
            end
            gtfr_pkg::MODE_IDLE, gtfr_pkg::MODE_ERROR: begin
              s1_nxt.ev = gtfr_pkg::EV_NONE;
            end
          endcase
        end
        gtfr_pkg::OP_START: begin
          mode_nxt       = gtfr_pkg::MODE_INIT;
          s1_nxt.restart = 1'b1;
        end
        gtfr_pkg::OP_READ: begin
          mem_re         = 1'b1;
          s1_nxt.rvalid  = ridx_x < cnt_x;
          s1_nxt.rd_pass = (ridx_x < cnt_x) &&
                           !((ridx_x == CMP_W'(gtfr_pkg::POS_CRC_LO) && z10_r) ||
                             (ridx_x == CMP_W'(gtfr_pkg::POS_CRC_HI) && z11_r));
        end
      endcase
    end
  end

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= gtfr_pkg::MODE_INIT;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // frame state, config and pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      crc_r       <= gtfr_pkg::CRC_INIT;
      exp_r       <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      z10_r       <= 1'b0;
      z11_r       <= 1'b0;
      min_r       <= gtfr_pkg::MIN_FRAME_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      exp_r   <= exp_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      z10_r   <= z10_nxt;
      z11_r   <= z11_nxt;
      if (cfg_wr_en) begin
        min_r <= cfg_wr_data;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_move && s1_valid_r) begin
      out_event_res     <= s1_r.ev;
      out_timer_restart <= s1_r.restart;
      out_timer_stop    <= s1_r.stop;
      out_source_addr   <= s1_r.src;
      out_dest_addr     <= s1_r.dst;
      out_pdu_length    <= s1_r.plen;
      out_read_byte     <= s1_r.rd_pass ? mem_rdata : '0;
      out_read_valid    <= s1_r.rvalid;
    end
  end

  assign out_valid = out_valid_r;

  gtfr_ram #(
    .WIDTH (gtfr_pkg::BYTE_W),
    .DEPTH (gtfr_pkg::MAX_FRAME)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (in_rx_byte),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule

### rtl/core/gtfr_chk.sv
// ----------------------------------------------------------------------------
// gtfr_chk
// Port-level checks of the frame receiver result channel.
// ----------------------------------------------------------------------------
`include "gap_timed_frame_receiver_crc_unit_assert.svh"

module gtfr_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [gtfr_pkg::EV_W-1:0]   out_event_res,
  input logic                        out_timer_restart,
  input logic                        out_timer_stop,
  input logic [gtfr_pkg::BYTE_W-1:0] out_source_addr,
  input logic [gtfr_pkg::BYTE_W-1:0] out_dest_addr,
  input logic [gtfr_pkg::PDU_W-1:0]  out_pdu_length,
  input logic [gtfr_pkg::BYTE_W-1:0] out_read_byte,
  input logic                        out_read_valid
);

  `GTFR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_event_res) && $stable(out_read_byte), "stalled result changed")
  `GTFR_ASSERT_IMP(a_stop_excl, out_valid && out_timer_stop, !out_timer_restart && !out_read_valid, "timer stop with restart or read")
  `GTFR_ASSERT_IMP(a_info_ok, out_valid && out_event_res != gtfr_pkg::EV_FRAME_OK, out_source_addr == '0 && out_dest_addr == '0 && out_pdu_length == '0, "frame info outside frame ok")
  `GTFR_ASSERT_IMP(a_read_zero, out_valid && !out_read_valid, out_read_byte == '0, "read byte without valid read")

endmodule

bind gap_timed_frame_receiver_crc_unit gtfr_chk u_gtfr_chk (.*);

### bench/tb_gap_timed_frame_receiver_crc_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gap_timed_frame_receiver_crc_unit
// Self-checking bench for the gap-timed frame receiver. A class mirrors the
// receiver's modes, frame store and CRC16, predicts one outcome per accepted
// input transfer and checks each result transfer in order. Stimulus is a
// directed opening, a maximum-size frame followed by bytes that overflow,
// then random well-formed frames mixed with broken frames and noise under
// three idling settings.
// ----------------------------------------------------------------------------
module tb_gap_timed_frame_receiver_crc_unit;

  // run limits
  localparam int unsigned CYCLE_LIMIT   = 250_000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_ITEMS   = 64;
  localparam int unsigned MAX_GAP       = 20;
  localparam int unsigned MAX_STALL_RUN = 16;
  localparam int unsigned SETTLE_CYCLES = 4;

  // frame layout and CRC, as the receiver sees them
  localparam logic [15:0] CRC_SEED      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
  localparam int unsigned CRC_FIRST     = 2;
  localparam int unsigned POS_LO        = 10;
  localparam int unsigned POS_HI        = 11;
  localparam int unsigned POS_S         = 20;
  localparam int unsigned POS_D         = 21;
  localparam int unsigned HDR_LEN       = 18;
  localparam int unsigned RUNT_LEN      = 5;
  localparam int unsigned RESET_MIN_LEN = 22;
  localparam int unsigned FRAME_CAP     = 1024;

  // one result transfer, field by field
  typedef struct packed {
    gtfr_pkg::event_t ev;
    logic             restart;
    logic             stop;
    logic [7:0]       src;
    logic [7:0]       dst;
    logic [9:0]       plen;
    logic [7:0]       rbyte;
    logic             rvalid;
  } rx_outcome_t;

  // --------------------------------------------------------------------------
  // Receiver mirror: keeps its own copy of mode, count, CRC and store, and
  // queues the outcome each accepted input transfer must produce.
  // --------------------------------------------------------------------------
  class rx_frame_checker;
    gtfr_pkg::mode_t rx_state;
    int unsigned     bytes_held;
    logic [15:0]     crc_acc;
    logic [15:0]     crc_from_frame;
    logic [7:0]      src_seen;
    logic [7:0]      dst_seen;
    logic [7:0]      shadow_buf [FRAME_CAP];
    bit              was_written [FRAME_CAP];
    int unsigned     min_len;
    rx_outcome_t     pending_outcomes [$];
    int unsigned     fail_cnt;

    function new();
      rx_state       = gtfr_pkg::MODE_INIT;
      bytes_held     = 0;
      crc_acc        = CRC_SEED;
      crc_from_frame = '0;
      src_seen       = '0;
      dst_seen       = '0;
      min_len        = RESET_MIN_LEN;
      fail_cnt       = 0;
      foreach (was_written[i]) was_written[i] = 1'b0;
    endfunction

    // reflected CRC16, LSB first
    static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      logic [15:0] v;
      v = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        v = {1'b0, v[15:1]} ^ (v[0] ? CRC_POLY_REFL : 16'h0000);
      end
      return v;
    endfunction

    function void set_min(int unsigned v);
      min_len = v;
    endfunction

    // entries past the count may only be read once something was stored there
    function bit readable(int unsigned idx);
      return (idx < bytes_held) || was_written[idx];
    endfunction

    function void store_byte(int unsigned pos, logic [7:0] b);
      shadow_buf[pos]  = b;
      was_written[pos] = 1'b1;
      if (pos >= CRC_FIRST) begin
        crc_acc = crc_byte(crc_acc, (pos == POS_LO || pos == POS_HI) ? 8'h00 : b);
      end
      if (pos == POS_LO) crc_from_frame[7:0] = b;
      else if (pos == POS_HI) crc_from_frame[15:8] = b;
      else if (pos == POS_S) src_seen = b;
      else if (pos == POS_D) dst_seen = b;
    endfunction

    function void predict_item(gtfr_pkg::op_t op, logic [7:0] b, logic [9:0] idx);
      rx_outcome_t o;
      o    = '0;
      o.ev = gtfr_pkg::EV_NONE;
      case (op)
        gtfr_pkg::OP_BYTE: begin
          o.restart = 1'b1;
          if (rx_state == gtfr_pkg::MODE_IDLE) begin
            crc_acc        = CRC_SEED;
            crc_from_frame = '0;
            src_seen       = '0;
            dst_seen       = '0;
            store_byte(0, b);
            bytes_held = 1;
            rx_state   = gtfr_pkg::MODE_RCV;
          end else if (rx_state == gtfr_pkg::MODE_RCV) begin
            if (bytes_held < FRAME_CAP) begin
              store_byte(bytes_held, b);
              bytes_held++;
            end else begin
              rx_state = gtfr_pkg::MODE_ERROR;
              o.ev     = gtfr_pkg::EV_OVERFLOW;
            end
          end
        end
        gtfr_pkg::OP_TIMEOUT: begin
          o.stop = 1'b1;
          if (rx_state == gtfr_pkg::MODE_INIT) begin
            o.ev = gtfr_pkg::EV_RDY;
          end else if (rx_state == gtfr_pkg::MODE_RCV) begin
            if (bytes_held < RUNT_LEN) begin
              o.ev = gtfr_pkg::EV_RUNT;
            end else if (bytes_held < min_len) begin
              o.ev = gtfr_pkg::EV_TOO_SHORT;
            end else begin
              // checked frames lose their CRC bytes in the store
              if (bytes_held > POS_LO) shadow_buf[POS_LO] = 8'h00;
              if (bytes_held > POS_HI) shadow_buf[POS_HI] = 8'h00;
              if (crc_acc == crc_from_frame) begin
                o.ev   = gtfr_pkg::EV_FRAME_OK;
                o.src  = src_seen;
                o.dst  = dst_seen;
                o.plen = (bytes_held > HDR_LEN) ? 10'(bytes_held - HDR_LEN) : 10'd0;
              end else begin
                o.ev = gtfr_pkg::EV_CRC_ERR;
              end
            end
          end
          rx_state = gtfr_pkg::MODE_IDLE;
        end
        gtfr_pkg::OP_START: begin
          rx_state  = gtfr_pkg::MODE_INIT;
          o.restart = 1'b1;
        end
        default: begin
          if (idx < bytes_held) begin
            o.rvalid = 1'b1;
            o.rbyte  = shadow_buf[idx];
          end
        end
      endcase
      pending_outcomes.push_back(o);
    endfunction

    task flag(string what, int got, int want);
      fail_cnt++;
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task check_outcome(rx_outcome_t got);
      rx_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        flag("result with nothing pending", 0, 0);
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.ev !== want.ev) flag("event_res", int'(got.ev), int'(want.ev));
      if (got.restart !== want.restart) flag("timer_restart", got.restart, want.restart);
      if (got.stop !== want.stop) flag("timer_stop", got.stop, want.stop);
      if (got.src !== want.src) flag("source_addr", got.src, want.src);
      if (got.dst !== want.dst) flag("dest_addr", got.dst, want.dst);
      if (got.plen !== want.plen) flag("pdu_length", got.plen, want.plen);
      if (got.rbyte !== want.rbyte) flag("read_byte", got.rbyte, want.rbyte);
      if (got.rvalid !== want.rvalid) flag("read_valid", got.rvalid, want.rvalid);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block and its ports
  // --------------------------------------------------------------------------
  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          cfg_wr_en     = 1'b0;
  logic [gtfr_pkg::CFG_W-1:0]    cfg_wr_data   = '0;
  logic                          in_valid      = 1'b0;
  logic                          in_stall;
  logic [1:0]                    in_operation  = '0;
  logic [7:0]                    in_rx_byte    = '0;
  logic [9:0]                    in_read_index = '0;
  logic                          out_valid;
  logic                          out_stall     = 1'b0;
  logic [gtfr_pkg::EV_W-1:0]     out_event_res;
  logic                          out_timer_restart;
  logic                          out_timer_stop;
  logic [7:0]                    out_source_addr;
  logic [7:0]                    out_dest_addr;
  logic [gtfr_pkg::PDU_W-1:0]    out_pdu_length;
  logic [7:0]                    out_read_byte;
  logic                          out_read_valid;

  gap_timed_frame_receiver_crc_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_rx_byte        (in_rx_byte),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_timer_restart (out_timer_restart),
    .out_timer_stop    (out_timer_stop),
    .out_source_addr   (out_source_addr),
    .out_dest_addr     (out_dest_addr),
    .out_pdu_length    (out_pdu_length),
    .out_read_byte     (out_read_byte),
    .out_read_valid    (out_read_valid)
  );

  rx_frame_checker board;
  logic [7:0]      frame_buf [FRAME_CAP];   // frame being built for sending
  int unsigned     send_idle_pct = 25;      // sender idle odds per cycle
  int unsigned     recv_idle_pct = 78;      // receiver stall odds per cycle
  int unsigned     items_sent    = 0;
  int unsigned     stall_run     = 0;
  int unsigned     cycle_cnt     = 0;
  bit              holding       = 1'b0;    // long receiver hold-off active
  event            hold_go;

  // 4 ns clock
  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_gap_timed_frame_receiver_crc_unit failed");
      $finish;
    end
  end

  // Long hold-off: counted at rising edges here, read by the receiver below.
  initial begin
    forever begin
      @(hold_go);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding = 1'b0;
    end
  end

  // Receiver: random stall at the falling edge, runs capped so the worst
  // case stays bounded; held solid while a hold-off is running.
  always @(negedge clk) begin
    if (holding) begin
      out_stall <= 1'b1;
      stall_run = 0;
    end else if (stall_run < MAX_STALL_RUN && $urandom_range(99) < recv_idle_pct) begin
      out_stall <= 1'b1;
      stall_run++;
    end else begin
      out_stall <= 1'b0;
      stall_run = 0;
    end
  end

  // Result monitor: a transfer is valid & !stall at the rising edge.
  always @(posedge clk) begin
    rx_outcome_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.ev      = gtfr_pkg::event_t'(out_event_res);
      seen.restart = out_timer_restart;
      seen.stop    = out_timer_stop;
      seen.src     = out_source_addr;
      seen.dst     = out_dest_addr;
      seen.plen    = out_pdu_length;
      seen.rbyte   = out_read_byte;
      seen.rvalid  = out_read_valid;
      board.check_outcome(seen);
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks. Each send returns just after the rising edge of its transfer;
  // the next one (or a drain) lowers or replaces valid at the falling edge.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [9:0] any_index();
    return 10'($urandom_range(1023));
  endfunction

  task automatic send_item(gtfr_pkg::op_t op, logic [7:0] b, logic [9:0] idx);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_rx_byte    <= b;
    in_read_index <= idx;
    do @(posedge clk); while (in_stall);
    board.predict_item(op, b, idx);
    items_sent++;
  endtask

  // Read-back; never touches a store entry that was never written.
  task automatic send_read();
    logic [9:0] idx;
    if (board.bytes_held > 0 && $urandom_range(1) == 0) begin
      idx = 10'($urandom_range(board.bytes_held - 1));
    end else begin
      idx = any_index();
    end
    if (!board.readable(idx)) begin
      if (board.bytes_held == 0) return;
      idx = 10'($urandom_range(board.bytes_held - 1));
    end
    send_item(gtfr_pkg::OP_READ, any_byte(), idx);
  endtask

  task automatic send_noise();
    gtfr_pkg::op_t op;
    op = gtfr_pkg::op_t'($urandom_range(3));
    if (op == gtfr_pkg::OP_READ) send_read();
    else send_item(op, any_byte(), any_index());
  endtask

  // One frame from idle. Frames long enough to carry a CRC get a matching
  // one at bytes 10/11, or one with a single bit flipped when bad.
  task automatic send_frame(int unsigned n, bit good, bit close, bit mix_reads);
    logic [15:0] c;
    if (board.rx_state != gtfr_pkg::MODE_IDLE) begin
      send_item(gtfr_pkg::OP_TIMEOUT, any_byte(), any_index());
    end
    for (int unsigned i = 0; i < n; i++) frame_buf[i] = any_byte();
    if (n > POS_HI) begin
      c = CRC_SEED;
      for (int unsigned i = CRC_FIRST; i < n; i++) begin
        c = rx_frame_checker::crc_byte(c,
              (i == POS_LO || i == POS_HI) ? 8'h00 : frame_buf[i]);
      end
      if (!good) c = c ^ (16'h0001 << $urandom_range(15));
      frame_buf[POS_LO] = c[7:0];
      frame_buf[POS_HI] = c[15:8];
    end
    for (int unsigned i = 0; i < n; i++) begin
      send_item(gtfr_pkg::OP_BYTE, frame_buf[i], any_index());
      if (mix_reads && $urandom_range(15) == 0) send_read();
    end
    if (close) send_item(gtfr_pkg::OP_TIMEOUT, any_byte(), any_index());
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Register writes only with the block empty.
  task automatic write_min(int unsigned v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= gtfr_pkg::CFG_W'(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.set_min(v);
  endtask

  // Receiver holds off while the sender keeps offering back to back, so the
  // pipeline fills and in_stall must rise.
  task automatic push_through_hold();
    int unsigned saved;
    saved         = send_idle_pct;
    send_idle_pct = 0;
    -> hold_go;
    send_frame(40, 1'b1, 1'b1, 1'b0);
    send_idle_pct = saved;
  endtask

  // Random phase: mostly well-formed frames, some broken ones, some noise.
  task automatic run_phase(int unsigned sender_pct, int unsigned receiver_pct,
                           int unsigned min_v);
    int unsigned start_cnt;
    int unsigned n;
    int unsigned lo;
    int unsigned r;
    bit          hold_done;
    bit          pause_done;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    write_min(min_v);
    start_cnt  = items_sent;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    while (items_sent - start_cnt < PHASE_ITEMS) begin
      if (!hold_done && items_sent - start_cnt > PHASE_ITEMS / 4) begin
        hold_done = 1'b1;
        push_through_hold();
      end
      if (!pause_done && items_sent - start_cnt > PHASE_ITEMS / 2) begin
        pause_done = 1'b1;
        drain_results();
      end
      r = $urandom_range(99);
      if (r < 65) begin
        // complete frame, usually long enough to be CRC-checked, mostly with a good CRC
        lo = (board.min_len > POS_HI + 1) ? board.min_len : POS_HI + 1;
        r  = $urandom_range(99);
        if (r < 60) n = $urandom_range(lo + 30, lo);
        else if (r < 85) n = $urandom_range(25, 1);
        else n = $urandom_range(80, 1);
        send_frame(n, $urandom_range(99) < 70, 1'b1, 1'b1);
        repeat ($urandom_range(3)) send_read();
      end else if (r < 80) begin
        // frame cut off by a start, or trailing into noise
        send_frame($urandom_range(40, 1), 1'b1, 1'b0, 1'b1);
        if ($urandom_range(1) == 1) begin
          send_item(gtfr_pkg::OP_START, any_byte(), any_index());
          repeat ($urandom_range(3)) begin
            send_item(gtfr_pkg::OP_BYTE, any_byte(), any_index());
          end
        end else begin
          repeat ($urandom_range(3, 1)) send_noise();
        end
      end else begin
        repeat ($urandom_range(6, 1)) send_noise();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // init mode: byte dropped, timeout reports ready, idle timeout is silent
    send_item(gtfr_pkg::OP_BYTE, 8'hFF, 10'h3FF);
    send_item(gtfr_pkg::OP_TIMEOUT, 8'h00, 10'h000);
    send_item(gtfr_pkg::OP_TIMEOUT, 8'hFF, 10'h3FF);
    send_item(gtfr_pkg::OP_START, 8'h00, 10'h000);
    send_item(gtfr_pkg::OP_START, 8'hFF, 10'h3FF);
    send_item(gtfr_pkg::OP_TIMEOUT, 8'h00, 10'h000);
    // runt frame, then read it back
    send_item(gtfr_pkg::OP_BYTE, 8'h00, 10'h000);
    send_item(gtfr_pkg::OP_BYTE, 8'hFF, 10'h3FF);
    send_item(gtfr_pkg::OP_BYTE, 8'h5A, 10'h155);
    send_item(gtfr_pkg::OP_TIMEOUT, 8'h00, 10'h000);
    send_item(gtfr_pkg::OP_READ, 8'h00, 10'h000);
    send_item(gtfr_pkg::OP_READ, 8'hFF, 10'h002);
    // five bytes against the default minimum: too short
    send_frame(5, 1'b1, 1'b1, 1'b0);
    send_item(gtfr_pkg::OP_READ, 8'h00, 10'h004);
    send_item(gtfr_pkg::OP_START, 8'h00, 10'h000);
    send_item(gtfr_pkg::OP_BYTE, 8'hA5, 10'h000);

    // small minimum: frames shorter than the address bytes get checked
    write_min(RUNT_LEN);
    send_frame(5, 1'b1, 1'b1, 1'b0);
    send_frame(11, 1'b1, 1'b1, 1'b0);
    send_frame(12, 1'b1, 1'b1, 1'b0);
    send_frame(21, 1'b1, 1'b1, 1'b0);
    send_frame(22, 1'b0, 1'b1, 1'b0);

    // largest minimum, then a full-size frame and bytes that overflow it
    write_min(FRAME_CAP);
    send_frame(40, 1'b1, 1'b1, 1'b0);
    send_frame(FRAME_CAP, 1'b1, 1'b0, 1'b0);
    send_item(gtfr_pkg::OP_BYTE, any_byte(), any_index());
    send_item(gtfr_pkg::OP_BYTE, any_byte(), any_index());
    send_item(gtfr_pkg::OP_TIMEOUT, any_byte(), any_index());
    send_item(gtfr_pkg::OP_READ, 8'h00, 10'h3FF);
    send_item(gtfr_pkg::OP_READ, 8'hFF, 10'h000);

    // random part under the three idling settings
    run_phase(25, 78, RESET_MIN_LEN);
    run_phase(78, 25, $urandom_range(40, RUNT_LEN));
    run_phase(0, 0, RUNT_LEN);

    drain_results();
    repeat (8) @(posedge clk);
    if (board.fail_cnt == 0 && board.pending_outcomes.size() == 0) begin
      $display("tb_gap_timed_frame_receiver_crc_unit passed");
    end else begin
      $display("tb_gap_timed_frame_receiver_crc_unit failed");
    end
    $finish;
  end

endmodule
